[hdl/seg_ovl_pkg.sv]
// Shared types and constants of the segment overlap classifier.
package seg_ovl_pkg;

	localparam int FIELD_W = 32;
	localparam int APB_DATA_W = 32;
	localparam int PADDR_W = 3;

	localparam logic [PADDR_W-1:0] ADDR_TOLERANCE = 3'h0;
	localparam logic [APB_DATA_W-1:0] TOL_RESET = 32'd4295;

	typedef enum logic [1:0] {
		KIND_CROSS    = 2'd0,
		KIND_OVERLAP  = 2'd1,
		KIND_TOUCH    = 2'd2,
		KIND_PARALLEL = 2'd3
	} kind_t;

	typedef struct packed {
		logic signed [FIELD_W-1:0] master_start_x;
		logic signed [FIELD_W-1:0] master_start_y;
		logic signed [FIELD_W-1:0] master_end_x;
		logic signed [FIELD_W-1:0] master_end_y;
		logic signed [FIELD_W-1:0] slave_start_x;
		logic signed [FIELD_W-1:0] slave_start_y;
		logic signed [FIELD_W-1:0] slave_end_x;
		logic signed [FIELD_W-1:0] slave_end_y;
	} pair_t;

	typedef struct packed {
		logic                      overlaps;
		kind_t                     case_kind;
		logic signed [FIELD_W-1:0] extent_low_x;
		logic signed [FIELD_W-1:0] extent_low_y;
		logic signed [FIELD_W-1:0] extent_high_x;
		logic signed [FIELD_W-1:0] extent_high_y;
	} result_t;

endpackage

[hdl/segment_overlap_classifier.sv]
// Top level of the segment overlap classifier: a pipeline with an output skid.
// Takes one segment pair word per cycle while pair_ready is high and returns one result word
// per pair, in order. The pipeline depth is set by the two crossing-point dividers, which
// resolve one quotient bit per stage over COORD_WIDTH + 1 stages. Seven stages ahead of them
// form the differences, the products, the sums, the classification and the crossing
// numerators. The whole pipeline moves together; a two-word output register and skid let it
// keep accepting while one finished word waits. The tolerance register resets to 4295
// (about 1e-6 in Q32.32) and may be rewritten only while the pipeline is empty.
module segment_overlap_classifier
	import seg_ovl_pkg::*;
#(
	parameter int COORD_WIDTH = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  pair_valid,
	output logic                  pair_ready,
	input  pair_t                 pair,
	output logic                  result_valid,
	input  logic                  result_ready,
	output result_t               result,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [PADDR_W-1:0]    paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready
);

	localparam int CW = COORD_WIDTH;
	localparam int DW = CW + 1;
	localparam int PW = 2 * DW;
	localparam int NW = PW + 1;
	localparam int CMPW = NW + 1;
	localparam int QB = DW;
	localparam int PWD = NW + DW;
	localparam int LH = (NW + 1) / 2;
	localparam int HH = NW - LH;
	localparam int VW = CW + 3;
	localparam int NSUM = 16;
	localparam int NSUB = 3;
	localparam int NPROD = 2 * NSUM;

	localparam logic signed [VW-1:0] CMAX = VW'((longint'(1) << (CW - 1)) - 1);
	localparam logic signed [VW-1:0] CMIN = -CMAX - VW'(1);

	localparam int IX_DEN  = 0;
	localparam int IX_NUM  = 1;
	localparam int IX_COL  = 2;
	localparam int IX_ABAB = 3;
	localparam int IX_CDCD = 4;
	localparam int IX_ABCD = 5;
	localparam int IX_ABAC = 6;
	localparam int IX_ABAD = 7;
	localparam int IX_CBCD = 8;
	localparam int IX_CBCB = 9;
	localparam int IX_CACA = 10;
	localparam int IX_ADCD = 11;
	localparam int IX_ADAD = 12;
	localparam int IX_BDBD = 13;
	localparam int IX_CDCA = 14;
	localparam int IX_CDBD = 15;

	localparam logic [1:0] PT_A = 2'd0;
	localparam logic [1:0] PT_B = 2'd1;
	localparam logic [1:0] PT_C = 2'd2;
	localparam logic [1:0] PT_D = 2'd3;

	typedef struct packed {
		logic signed [CW-1:0] ax, ay, bx, by, cx, cy, dx, dy;
		logic signed [DW-1:0] abx, aby;
	} geo_t;

	typedef struct packed {
		logic signed [DW-1:0] abx, aby, cdx, cdy, acx, acy, cax, cay;
		logic signed [DW-1:0] cbx, cby, adx, ady, bdx, bdy;
	} dif_t;

	typedef struct packed {
		kind_t                kind;
		logic signed [CW-1:0] lo_x, lo_y, hi_x, hi_y;
		logic signed [CW-1:0] ax, ay;
		logic                 negx, negy;
		logic                 ovfx, ovfy;
		logic [NW-1:0]        dmag;
	} side_t;

	typedef struct packed {
		logic [NW-1:0] rem;
		logic [QB-1:0] low;
		logic [QB-1:0] quo;
	} div_t;

	function automatic div_t div_step(input div_t d, input logic [NW-1:0] dm);
		div_t n;
		logic [NW:0] trial;
		trial = {d.rem, d.low[QB-1]};
		n.low = d.low << 1;
		if (trial >= {1'b0, dm}) begin
			n.rem = NW'(trial - {1'b0, dm});
			n.quo = {d.quo[QB-2:0], 1'b1};
		end else begin
			n.rem = trial[NW-1:0];
			n.quo = {d.quo[QB-2:0], 1'b0};
		end
		return n;
	endfunction

	function automatic logic signed [CW-1:0] pick(input logic [1:0] idx, input geo_t g,
			input logic want_y);
		logic signed [CW-1:0] r;
		case (idx)
			PT_A: r = want_y ? g.ay : g.ax;
			PT_B: r = want_y ? g.by : g.bx;
			PT_C: r = want_y ? g.cy : g.cx;
			PT_D: r = want_y ? g.dy : g.dx;
			default: r = '0;
		endcase
		return r;
	endfunction

	// Adds the signed quotient to the start coordinate and clamps to the coordinate range.
	function automatic logic signed [FIELD_W-1:0] crossing(input logic signed [CW-1:0] a,
			input logic [QB-1:0] q, input logic neg, input logic ovf);
		logic signed [VW-1:0] qs;
		logic signed [VW-1:0] v;
		logic signed [VW-1:0] r;
		qs = VW'(q);
		v = VW'(a) + (neg ? -qs : qs);
		if (ovf) begin
			r = neg ? CMIN : CMAX;
		end else if (v > CMAX) begin
			r = CMAX;
		end else if (v < CMIN) begin
			r = CMIN;
		end else begin
			r = v;
		end
		return FIELD_W'(r);
	endfunction

	logic [APB_DATA_W-1:0] tol_q;
	logic                  cfg_hit;
	logic                  adv;

	logic                     v_s1, v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	logic                     v_s8 [QB];
	geo_t                     geo_n, geo_s1, geo_s2, geo_s3;
	dif_t                     dif_n, dif_s1;
	logic signed [DW-1:0]     opa [NPROD];
	logic signed [DW-1:0]     opb [NPROD];
	logic signed [PW-1:0]     prod_s2 [NPROD];
	logic signed [CMPW-1:0]   sum_s3 [NSUM];
	side_t                    side_n, side_s4, side_s5, side_s6, side_s7;
	side_t                    side_ovf_n;
	side_t                    side_s8 [QB];
	logic [NW-1:0]            nmag_n, nmag_s4;
	logic [DW-1:0]            axmag_n, aymag_n, axmag_s4, aymag_s4;
	logic [LH+DW-1:0]         ppx_lo_s5, ppy_lo_s5;
	logic [HH+DW-1:0]         ppx_hi_s5, ppy_hi_s5;
	logic [PWD-1:0]           pmagx_s6, pmagy_s6;
	div_t                     xdiv_s7, ydiv_s7;
	div_t                     xdiv_s8 [QB];
	div_t                     ydiv_s8 [QB];
	result_t                  fin;
	result_t                  res_q, skid_q;
	logic                     res_vld_q, skid_vld_q;

	// Configuration port.
	assign pready = 1'b1;
	assign cfg_hit = (paddr[PADDR_W-1:2] == ADDR_TOLERANCE[PADDR_W-1:2]);
	assign prdata = cfg_hit ? tol_q : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q <= TOL_RESET;
		end else if (psel && penable && pwrite && pready && cfg_hit) begin
			tol_q <= pwdata;
		end
	end

	// The whole pipeline advances unless the skid holds a word.
	assign adv = !skid_vld_q;
	assign pair_ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			for (int j = 0; j < QB; j++) begin
				v_s8[j] <= 1'b0;
			end
		end else if (adv) begin
			v_s1 <= pair_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8[0] <= v_s7;
			for (int j = 1; j < QB; j++) begin
				v_s8[j] <= v_s8[j-1];
			end
		end
	end

	// Stage 1: coordinates and the differences between endpoints.
	always_comb begin
		geo_n.ax = pair.master_start_x[CW-1:0];
		geo_n.ay = pair.master_start_y[CW-1:0];
		geo_n.bx = pair.master_end_x[CW-1:0];
		geo_n.by = pair.master_end_y[CW-1:0];
		geo_n.cx = pair.slave_start_x[CW-1:0];
		geo_n.cy = pair.slave_start_y[CW-1:0];
		geo_n.dx = pair.slave_end_x[CW-1:0];
		geo_n.dy = pair.slave_end_y[CW-1:0];
		dif_n.abx = DW'(geo_n.bx) - DW'(geo_n.ax);
		dif_n.aby = DW'(geo_n.by) - DW'(geo_n.ay);
		dif_n.cdx = DW'(geo_n.dx) - DW'(geo_n.cx);
		dif_n.cdy = DW'(geo_n.dy) - DW'(geo_n.cy);
		dif_n.acx = DW'(geo_n.cx) - DW'(geo_n.ax);
		dif_n.acy = DW'(geo_n.cy) - DW'(geo_n.ay);
		dif_n.cax = DW'(geo_n.ax) - DW'(geo_n.cx);
		dif_n.cay = DW'(geo_n.ay) - DW'(geo_n.cy);
		dif_n.cbx = DW'(geo_n.bx) - DW'(geo_n.cx);
		dif_n.cby = DW'(geo_n.by) - DW'(geo_n.cy);
		dif_n.adx = DW'(geo_n.dx) - DW'(geo_n.ax);
		dif_n.ady = DW'(geo_n.dy) - DW'(geo_n.ay);
		dif_n.bdx = DW'(geo_n.dx) - DW'(geo_n.bx);
		dif_n.bdy = DW'(geo_n.dy) - DW'(geo_n.by);
		geo_n.abx = dif_n.abx;
		geo_n.aby = dif_n.aby;
	end

	// Product operands: each pair of entries forms one sum or difference in stage 3.
	always_comb begin
		opa[2*IX_DEN]    = dif_s1.abx; opb[2*IX_DEN]    = dif_s1.cdy;
		opa[2*IX_DEN+1]  = dif_s1.aby; opb[2*IX_DEN+1]  = dif_s1.cdx;
		opa[2*IX_NUM]    = dif_s1.cay; opb[2*IX_NUM]    = dif_s1.cdx;
		opa[2*IX_NUM+1]  = dif_s1.cax; opb[2*IX_NUM+1]  = dif_s1.cdy;
		opa[2*IX_COL]    = dif_s1.cby; opb[2*IX_COL]    = dif_s1.abx;
		opa[2*IX_COL+1]  = dif_s1.aby; opb[2*IX_COL+1]  = dif_s1.cbx;
		opa[2*IX_ABAB]   = dif_s1.abx; opb[2*IX_ABAB]   = dif_s1.abx;
		opa[2*IX_ABAB+1] = dif_s1.aby; opb[2*IX_ABAB+1] = dif_s1.aby;
		opa[2*IX_CDCD]   = dif_s1.cdx; opb[2*IX_CDCD]   = dif_s1.cdx;
		opa[2*IX_CDCD+1] = dif_s1.cdy; opb[2*IX_CDCD+1] = dif_s1.cdy;
		opa[2*IX_ABCD]   = dif_s1.abx; opb[2*IX_ABCD]   = dif_s1.cdx;
		opa[2*IX_ABCD+1] = dif_s1.aby; opb[2*IX_ABCD+1] = dif_s1.cdy;
		opa[2*IX_ABAC]   = dif_s1.abx; opb[2*IX_ABAC]   = dif_s1.acx;
		opa[2*IX_ABAC+1] = dif_s1.aby; opb[2*IX_ABAC+1] = dif_s1.acy;
		opa[2*IX_ABAD]   = dif_s1.abx; opb[2*IX_ABAD]   = dif_s1.adx;
		opa[2*IX_ABAD+1] = dif_s1.aby; opb[2*IX_ABAD+1] = dif_s1.ady;
		opa[2*IX_CBCD]   = dif_s1.cbx; opb[2*IX_CBCD]   = dif_s1.cdx;
		opa[2*IX_CBCD+1] = dif_s1.cby; opb[2*IX_CBCD+1] = dif_s1.cdy;
		opa[2*IX_CBCB]   = dif_s1.cbx; opb[2*IX_CBCB]   = dif_s1.cbx;
		opa[2*IX_CBCB+1] = dif_s1.cby; opb[2*IX_CBCB+1] = dif_s1.cby;
		opa[2*IX_CACA]   = dif_s1.cax; opb[2*IX_CACA]   = dif_s1.cax;
		opa[2*IX_CACA+1] = dif_s1.cay; opb[2*IX_CACA+1] = dif_s1.cay;
		opa[2*IX_ADCD]   = dif_s1.adx; opb[2*IX_ADCD]   = dif_s1.cdx;
		opa[2*IX_ADCD+1] = dif_s1.ady; opb[2*IX_ADCD+1] = dif_s1.cdy;
		opa[2*IX_ADAD]   = dif_s1.adx; opb[2*IX_ADAD]   = dif_s1.adx;
		opa[2*IX_ADAD+1] = dif_s1.ady; opb[2*IX_ADAD+1] = dif_s1.ady;
		opa[2*IX_BDBD]   = dif_s1.bdx; opb[2*IX_BDBD]   = dif_s1.bdx;
		opa[2*IX_BDBD+1] = dif_s1.bdy; opb[2*IX_BDBD+1] = dif_s1.bdy;
		opa[2*IX_CDCA]   = dif_s1.cdx; opb[2*IX_CDCA]   = dif_s1.cax;
		opa[2*IX_CDCA+1] = dif_s1.cdy; opb[2*IX_CDCA+1] = dif_s1.cay;
		opa[2*IX_CDBD]   = dif_s1.cdx; opb[2*IX_CDBD]   = dif_s1.bdx;
		opa[2*IX_CDBD+1] = dif_s1.cdy; opb[2*IX_CDBD+1] = dif_s1.bdy;
	end

	// Stage 4 decisions, taken from the registered sums.
	always_comb begin
		logic signed [CMPW-1:0] t, nt, den, num, col, hiab, offs;
		logic signed [CMPW-1:0] abab, cdcd, abcd, abac, abad;
		logic                   mshort, found;
		logic [1:0]             lo, hi;
		logic signed [CMPW-1:0] negd, negn;
		t = CMPW'(tol_q);
		nt = -t;
		den = sum_s3[IX_DEN];
		num = sum_s3[IX_NUM];
		col = sum_s3[IX_COL];
		abab = sum_s3[IX_ABAB];
		cdcd = sum_s3[IX_CDCD];
		abcd = sum_s3[IX_ABCD];
		abac = sum_s3[IX_ABAC];
		abad = sum_s3[IX_ABAD];
		hiab = abab + t;
		mshort = abab < cdcd;
		found = 1'b0;
		lo = PT_A;
		hi = PT_A;
		offs = '0;
		side_n.kind = KIND_TOUCH;
		if (!(den <= t && den >= nt)) begin
			side_n.kind = KIND_CROSS;
		end else if (!(col < t && col > nt)) begin
			side_n.kind = KIND_PARALLEL;
		end else begin
			if (!(abac < nt) && !(hiab < abac)) begin
				// The slave start lies on the master segment.
				offs = abac - abab;
				if (abac <= t && abac >= nt) begin
					if (t < abcd) begin
						found = 1'b1;
						lo = PT_A;
						hi = mshort ? PT_B : PT_D;
					end
				end else if (offs < t && offs > nt) begin
					if (t < -abcd) begin
						found = 1'b1;
						hi = PT_B;
						lo = mshort ? PT_A : PT_D;
					end
				end else begin
					found = 1'b1;
					if (t < sum_s3[IX_CBCD]) begin
						lo = PT_C;
						hi = (sum_s3[IX_CBCB] < cdcd) ? PT_B : PT_D;
					end else begin
						hi = PT_C;
						lo = (sum_s3[IX_CACA] < cdcd) ? PT_A : PT_D;
					end
				end
			end else if (!(abad < nt) && !(hiab < abad)) begin
				// The slave end lies on the master segment.
				offs = abad - abab;
				if (abad <= t && abad >= nt) begin
					if (t < -abcd) begin
						found = 1'b1;
						lo = PT_A;
						hi = mshort ? PT_B : PT_C;
					end
				end else if (offs < t && offs > nt) begin
					if (t < abcd) begin
						found = 1'b1;
						hi = PT_B;
						lo = mshort ? PT_A : PT_C;
					end
				end else begin
					found = 1'b1;
					if (t < sum_s3[IX_ADCD]) begin
						hi = PT_D;
						lo = (sum_s3[IX_ADAD] < cdcd) ? PT_A : PT_C;
					end else begin
						lo = PT_D;
						hi = (sum_s3[IX_BDBD] < cdcd) ? PT_B : PT_C;
					end
				end
			end else if (t < sum_s3[IX_CDCA] && t < sum_s3[IX_CDBD]) begin
				// The master segment lies inside the slave.
				found = 1'b1;
				lo = PT_A;
				hi = PT_B;
			end
			side_n.kind = found ? KIND_OVERLAP : KIND_TOUCH;
		end
		if (side_n.kind == KIND_OVERLAP) begin
			side_n.lo_x = pick(lo, geo_s3, 1'b0);
			side_n.lo_y = pick(lo, geo_s3, 1'b1);
			side_n.hi_x = pick(hi, geo_s3, 1'b0);
			side_n.hi_y = pick(hi, geo_s3, 1'b1);
		end else begin
			side_n.lo_x = '0;
			side_n.lo_y = '0;
			side_n.hi_x = '0;
			side_n.hi_y = '0;
		end
		negd = -den;
		negn = -num;
		side_n.dmag = den[CMPW-1] ? negd[NW-1:0] : den[NW-1:0];
		nmag_n = num[CMPW-1] ? negn[NW-1:0] : num[NW-1:0];
		axmag_n = geo_s3.abx[DW-1] ? DW'(-geo_s3.abx) : DW'(geo_s3.abx);
		aymag_n = geo_s3.aby[DW-1] ? DW'(-geo_s3.aby) : DW'(geo_s3.aby);
		side_n.negx = num[CMPW-1] ^ geo_s3.abx[DW-1] ^ den[CMPW-1];
		side_n.negy = num[CMPW-1] ^ geo_s3.aby[DW-1] ^ den[CMPW-1];
		side_n.ax = geo_s3.ax;
		side_n.ay = geo_s3.ay;
		side_n.ovfx = 1'b0;
		side_n.ovfy = 1'b0;
	end

	// A quotient too wide for the divider stages saturates in any case.
	always_comb begin
		side_ovf_n = side_s6;
		side_ovf_n.ovfx = pmagx_s6 >= (PWD'(side_s6.dmag) << QB);
		side_ovf_n.ovfy = pmagy_s6 >= (PWD'(side_s6.dmag) << QB);
	end

	// Pipeline payload.
	always_ff @(posedge clk) begin
		if (adv) begin
			geo_s1 <= geo_n;
			dif_s1 <= dif_n;

			for (int k = 0; k < NPROD; k++) begin
				prod_s2[k] <= PW'(opa[k]) * PW'(opb[k]);
			end
			geo_s2 <= geo_s1;

			for (int j = 0; j < NSUM; j++) begin
				if (j < NSUB) begin
					sum_s3[j] <= CMPW'(prod_s2[2*j]) - CMPW'(prod_s2[2*j+1]);
				end else begin
					sum_s3[j] <= CMPW'(prod_s2[2*j]) + CMPW'(prod_s2[2*j+1]);
				end
			end
			geo_s3 <= geo_s2;

			side_s4 <= side_n;
			nmag_s4 <= nmag_n;
			axmag_s4 <= axmag_n;
			aymag_s4 <= aymag_n;

			// The wide numerator product is split into two partial products.
			ppx_lo_s5 <= (LH+DW)'(nmag_s4[LH-1:0]) * (LH+DW)'(axmag_s4);
			ppx_hi_s5 <= (HH+DW)'(nmag_s4[NW-1:LH]) * (HH+DW)'(axmag_s4);
			ppy_lo_s5 <= (LH+DW)'(nmag_s4[LH-1:0]) * (LH+DW)'(aymag_s4);
			ppy_hi_s5 <= (HH+DW)'(nmag_s4[NW-1:LH]) * (HH+DW)'(aymag_s4);
			side_s5 <= side_s4;

			pmagx_s6 <= PWD'(ppx_lo_s5) + (PWD'(ppx_hi_s5) << LH);
			pmagy_s6 <= PWD'(ppy_lo_s5) + (PWD'(ppy_hi_s5) << LH);
			side_s6 <= side_s5;

			xdiv_s7.rem <= pmagx_s6[PWD-1:QB];
			xdiv_s7.low <= pmagx_s6[QB-1:0];
			xdiv_s7.quo <= '0;
			ydiv_s7.rem <= pmagy_s6[PWD-1:QB];
			ydiv_s7.low <= pmagy_s6[QB-1:0];
			ydiv_s7.quo <= '0;
			side_s7 <= side_ovf_n;

			xdiv_s8[0] <= div_step(xdiv_s7, side_s7.dmag);
			ydiv_s8[0] <= div_step(ydiv_s7, side_s7.dmag);
			side_s8[0] <= side_s7;
			for (int j = 1; j < QB; j++) begin
				xdiv_s8[j] <= div_step(xdiv_s8[j-1], side_s8[j-1].dmag);
				ydiv_s8[j] <= div_step(ydiv_s8[j-1], side_s8[j-1].dmag);
				side_s8[j] <= side_s8[j-1];
			end
		end
	end

	// Final word, formed from the last divider stage.
	always_comb begin
		fin.case_kind = side_s8[QB-1].kind;
		fin.overlaps = (side_s8[QB-1].kind == KIND_OVERLAP);
		if (side_s8[QB-1].kind == KIND_CROSS) begin
			fin.extent_low_x = crossing(side_s8[QB-1].ax, xdiv_s8[QB-1].quo,
				side_s8[QB-1].negx, side_s8[QB-1].ovfx);
			fin.extent_low_y = crossing(side_s8[QB-1].ay, ydiv_s8[QB-1].quo,
				side_s8[QB-1].negy, side_s8[QB-1].ovfy);
			fin.extent_high_x = fin.extent_low_x;
			fin.extent_high_y = fin.extent_low_y;
		end else begin
			fin.extent_low_x = FIELD_W'(side_s8[QB-1].lo_x);
			fin.extent_low_y = FIELD_W'(side_s8[QB-1].lo_y);
			fin.extent_high_x = FIELD_W'(side_s8[QB-1].hi_x);
			fin.extent_high_y = FIELD_W'(side_s8[QB-1].hi_y);
		end
	end

	// Output register and skid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_q <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (skid_vld_q) begin
			if (result_ready) begin
				skid_vld_q <= 1'b0;
			end
		end else if (!res_vld_q || result_ready) begin
			res_vld_q <= v_s8[QB-1];
		end else if (v_s8[QB-1]) begin
			skid_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_vld_q) begin
			if (result_ready) begin
				res_q <= skid_q;
			end
		end else if (!res_vld_q || result_ready) begin
			res_q <= fin;
		end else begin
			skid_q <= fin;
		end
	end

	assign result_valid = res_vld_q;
	assign result = res_q;

	// The skid only fills behind a word that is held in the output register.
	a_skid_behind_output: assert property (@(posedge clk) disable iff (!arst_n)
		skid_vld_q |-> res_vld_q)
		else $error("skid holds a word while the output register is empty");

	a_skid_fills_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_vld_q) |-> $past(result_valid && !result_ready))
		else $error("skid filled without an output stall");

	a_flag_matches_kind: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result.overlaps == (result.case_kind == KIND_OVERLAP)))
		else $error("overlap flag disagrees with the case kind");

	a_no_extent_without_contact: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result.case_kind == KIND_TOUCH || result.case_kind == KIND_PARALLEL)
		|-> (result.extent_low_x == '0 && result.extent_low_y == '0 &&
			result.extent_high_x == '0 && result.extent_high_y == '0))
		else $error("extents set for segments that neither cross nor overlap");

	a_crossing_is_point: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.case_kind == KIND_CROSS
		|-> (result.extent_low_x == result.extent_high_x &&
			result.extent_low_y == result.extent_high_y))
		else $error("crossing word carries two different points");

endmodule
